### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define LBBC_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LBBC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LBBC_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define LBBC_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

### src/lbbc_pkg.sv
// ----------------------------------------------------------------------------
// Bitrate controller package
// Types, codes and constants shared by the loss-based bitrate controller.
// ----------------------------------------------------------------------------
package lbbc_pkg;

   // Parameter defaults
   localparam int START_DELAY_TICKS_DEFAULT = 3;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_ABR_MODE        = 1'b0;
   localparam logic CSR_IDX_INITIAL_BITRATE = 1'b1;

   // Opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Modes
   localparam logic [1:0] MODE_BALANCED    = 2'd0;
   localparam logic [1:0] MODE_QUALITY     = 2'd1;
   localparam logic [1:0] MODE_LOW_LATENCY = 2'd2;

   // Reason codes
   localparam logic [2:0] REASON_NONE      = 3'd0;
   localparam logic [2:0] REASON_EMERGENCY = 3'd1;
   localparam logic [2:0] REASON_SUSTAINED = 3'd2;
   localparam logic [2:0] REASON_MILD      = 3'd3;
   localparam logic [2:0] REASON_PROBE     = 3'd4;
   localparam logic [2:0] REASON_CLAMP     = 3'd5;

   // Directions
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   // Reset bounds: balanced mode with zero initial rate
   localparam logic [19:0] RESET_MIN_RATE = 20'd3000;
   localparam logic [19:0] RESET_MAX_RATE = 20'd0;

   typedef struct packed {
      logic [1:0]  abr_mode;
      logic [18:0] initial_bitrate;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic        stats_valid;
      logic [13:0] loss_centi;
      logic [31:0] now_ms;
      logic        sink_accepts;
   } req_type;

   typedef struct packed {
      logic [19:0] bitrate;
      logic        bitrate_changed;
      logic        evaluated;
      logic [2:0]  reason_code;
      logic [1:0]  direction;
   } rsp_type;

   typedef struct packed {
      logic [19:0] rate;
      logic [19:0] min_rate;
      logic [19:0] max_rate;
      logic [1:0]  mode;
      logic [7:0]  stable_count;
      logic [7:0]  loss_run;
      logic [31:0] last_change_ms;
      logic [1:0]  last_dir;
      logic [7:0]  ticks_seen;
   } state_type;

   localparam state_type STATE_RESET = '{
      rate:           20'd0,
      min_rate:       RESET_MIN_RATE,
      max_rate:       RESET_MAX_RATE,
      mode:           MODE_BALANCED,
      stable_count:   8'd0,
      loss_run:       8'd0,
      last_change_ms: 32'd0,
      last_dir:       DIR_NONE,
      ticks_seen:     8'd0
   };

endpackage

### src/lbbc_channels.sv
// ----------------------------------------------------------------------------
// Bitrate controller channels
// Valid/ready channel interfaces for request and response words.
// ----------------------------------------------------------------------------
interface lbbc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic        stats_valid;
   logic [13:0] loss_centi;
   logic [31:0] now_ms;
   logic        sink_accepts;

   modport source (
      output valid, opcode, stats_valid, loss_centi, now_ms, sink_accepts,
      input  ready
   );
   modport sink (
      input  valid, opcode, stats_valid, loss_centi, now_ms, sink_accepts,
      output ready
   );
endinterface

interface lbbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] bitrate;
   logic        bitrate_changed;
   logic        evaluated;
   logic [2:0]  reason_code;
   logic [1:0]  direction;

   modport source (
      output valid, bitrate, bitrate_changed, evaluated, reason_code, direction,
      input  ready
   );
   modport sink (
      input  valid, bitrate, bitrate_changed, evaluated, reason_code, direction,
      output ready
   );
endinterface

### src/loss_based_bitrate_controller_core.sv
// ----------------------------------------------------------------------------
// Loss-based bitrate controller core
// Local adaptive bitrate control from per-second packet loss statistics.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per tick (opcode 0) or start (opcode 1); rsp returns
//   exactly one word per request with the current bitrate, whether it changed,
//   whether the loss rules ran, the reason and the last committed direction.
//   Mode and initial bitrate are written over the APB-style port; a start word
//   latches them and derives the rate bounds.
// Pipeline: an accepted request sits in the input register, is evaluated
//   in one pass and its response enters the output register when it advances.
// Throughput: one word per cycle unless rsp stalls; the state register updates
//   on the cycle a word moves from the input register to the output register.
// Reset: clears both registers' valid flags and sets the controller state to
//   the balanced-mode, zero-rate start state.
// Stall: while rsp is held the output word stays; the input register still
//   takes one more word, then req.ready drops until rsp drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module loss_based_bitrate_controller_core #(
   parameter int START_DELAY_TICKS = lbbc_pkg::START_DELAY_TICKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   lbbc_req_if.sink                          req,
   lbbc_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lbbc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lbbc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lbbc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   lbbc_pkg::cfg_type   cfg;
   lbbc_pkg::state_type st;
   lbbc_pkg::state_type nxt;
   lbbc_pkg::rsp_type   res;
   lbbc_pkg::req_type   req_word;

   logic                in_valid_ff;
   logic                in_valid_in;
   lbbc_pkg::req_type   in_item_ff;
   lbbc_pkg::req_type   in_item_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   lbbc_pkg::rsp_type   out_rsp_ff;
   lbbc_pkg::rsp_type   out_rsp_in;
   logic                advance;
   logic                take;

   lbbc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lbbc_eval #(
      .START_DELAY_TICKS (START_DELAY_TICKS)
   ) u_eval (
      .item (in_item_ff),
      .st   (st),
      .cfg  (cfg),
      .nxt  (nxt),
      .res  (res)
   );

   lbbc_state u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .nxt     (nxt),
      .st      (st)
   );

   assign req_word.opcode       = req.opcode;
   assign req_word.stats_valid  = req.stats_valid;
   assign req_word.loss_centi   = req.loss_centi;
   assign req_word.now_ms       = req.now_ms;
   assign req_word.sink_accepts = req.sink_accepts;

   // advance when the output slot is free or draining this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign take      = req.valid && req.ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign in_item_in   = take ? req_word : in_item_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);
   assign out_rsp_in   = advance ? res : out_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.bitrate         = out_rsp_ff.bitrate;
   assign rsp.bitrate_changed = out_rsp_ff.bitrate_changed;
   assign rsp.evaluated       = out_rsp_ff.evaluated;
   assign rsp.reason_code     = out_rsp_ff.reason_code;
   assign rsp.direction       = out_rsp_ff.direction;

   `LBBC_ASSERT_IMPL(a_changed_needs_eval, clock, reset, rsp.valid && rsp.bitrate_changed, rsp.evaluated, "committed change without evaluation")
   `LBBC_ASSERT_IMPL(a_skip_has_no_reason, clock, reset, rsp.valid && !rsp.evaluated, rsp.reason_code == lbbc_pkg::REASON_NONE, "reason reported on skipped word")
   `LBBC_ASSERT_IMPL(a_changed_has_reason, clock, reset, rsp.valid && rsp.bitrate_changed, rsp.reason_code != lbbc_pkg::REASON_NONE, "change without a reason")
   `LBBC_ASSERT_NEXT(a_state_holds, clock, reset, !advance, $stable(st), "state moved without a word advancing")
   `LBBC_ASSERT_IMPL(a_backpressure_full, clock, reset, !req.ready, in_valid_ff && out_valid_ff, "request stalled with a free slot")

endmodule

### src/lbbc_csr.sv
// ----------------------------------------------------------------------------
// Bitrate controller registers
// APB-style register file holding mode and initial bitrate.
// ----------------------------------------------------------------------------
module lbbc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lbbc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lbbc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lbbc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output lbbc_pkg::cfg_type                 cfg
);

   logic [1:0]  abr_mode_ff;
   logic [1:0]  abr_mode_in;
   logic [18:0] initial_bitrate_ff;
   logic [18:0] initial_bitrate_in;
   logic        wr_en;
   logic        word_idx;

   // byte offset bits are ignored
   assign word_idx = paddr[2];
   assign wr_en    = psel && penable && pwrite;
   assign pready   = 1'b1;

   always_comb begin
      abr_mode_in        = abr_mode_ff;
      initial_bitrate_in = initial_bitrate_ff;
      if (wr_en) begin
         case (word_idx)
            lbbc_pkg::CSR_IDX_ABR_MODE:        abr_mode_in = pwdata[1:0];
            lbbc_pkg::CSR_IDX_INITIAL_BITRATE: initial_bitrate_in = pwdata[18:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abr_mode_ff        <= lbbc_pkg::MODE_BALANCED;
         initial_bitrate_ff <= 19'd0;
      end else begin
         abr_mode_ff        <= abr_mode_in;
         initial_bitrate_ff <= initial_bitrate_in;
      end
   end

   always_comb begin
      case (word_idx)
         lbbc_pkg::CSR_IDX_ABR_MODE:
            prdata = {{(lbbc_pkg::CSR_DATA_W-2){1'b0}}, abr_mode_ff};
         lbbc_pkg::CSR_IDX_INITIAL_BITRATE:
            prdata = {{(lbbc_pkg::CSR_DATA_W-19){1'b0}}, initial_bitrate_ff};
         default:
            prdata = '0;
      endcase
   end

   assign cfg.abr_mode        = abr_mode_ff;
   assign cfg.initial_bitrate = initial_bitrate_ff;

endmodule

### src/lbbc_eval.sv
// ----------------------------------------------------------------------------
// Bitrate controller evaluation
// Classifies loss, scales and clamps the rate, and forms the next state.
// ----------------------------------------------------------------------------
module lbbc_eval #(
   parameter int START_DELAY_TICKS = lbbc_pkg::START_DELAY_TICKS_DEFAULT
) (
   input  lbbc_pkg::req_type   item,
   input  lbbc_pkg::state_type st,
   input  lbbc_pkg::cfg_type   cfg,
   output lbbc_pkg::state_type nxt,
   output lbbc_pkg::rsp_type   res
);

   typedef enum logic [2:0] {
      SCALE_KEEP,
      SCALE_70,
      SCALE_90,
      SCALE_95,
      SCALE_102,
      SCALE_105
   } scale_type;

   // x*num/den folded into one reciprocal multiply: (x * num * ceil(2^k/den)) >> k
   localparam logic [63:0] K_70  = 64'd7  * (((64'd1 << 27) + 64'd9)  / 64'd10);
   localparam logic [63:0] K_90  = 64'd9  * (((64'd1 << 27) + 64'd9)  / 64'd10);
   localparam logic [63:0] K_95  = 64'd19 * (((64'd1 << 30) + 64'd19) / 64'd20);
   localparam logic [63:0] K_102 = 64'd51 * (((64'd1 << 32) + 64'd49) / 64'd50);
   localparam logic [63:0] K_105 = 64'd21 * (((64'd1 << 30) + 64'd19) / 64'd20);
   localparam logic [63:0] K_3_10 = 64'd3 * (((64'd1 << 25) + 64'd9) / 64'd10);
   localparam logic [63:0] K_6_5  = 64'd6 * (((64'd1 << 25) + 64'd4) / 64'd5);

   localparam logic [7:0]  DELAY_TICKS  = 8'(START_DELAY_TICKS);
   localparam logic [13:0] LOSS_EMERG   = 14'd500;
   localparam logic [13:0] LOSS_SUST    = 14'd200;
   localparam logic [13:0] LOSS_MILD    = 14'd50;
   localparam logic [7:0]  RUN_SUST     = 8'd2;
   localparam logic [7:0]  RUN_MILD     = 8'd4;
   localparam logic [7:0]  PROBE_QUAL   = 8'd3;
   localparam logic [7:0]  PROBE_OTHER  = 8'd5;
   localparam logic [31:0] COOL_LL      = 32'd1500;
   localparam logic [31:0] COOL_OTHER   = 32'd2000;
   localparam logic [19:0] RATE_CAP     = 20'd150000;
   localparam logic [19:0] FLOOR_BAL    = 20'd3000;
   localparam logic [19:0] FLOOR_QUAL   = 20'd5000;
   localparam logic [19:0] FLOOR_LL     = 20'd2000;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? 8'hFF : v + 8'd1;
   endfunction

   function automatic logic [20:0] scale_rate(input logic [19:0] cur, input scale_type sel);
      logic [63:0] p;
      logic [20:0] r;
      p = '0;
      case (sel)
         SCALE_70: begin
            p = 64'(cur) * K_70;
            r = p[47:27];
         end
         SCALE_90: begin
            p = 64'(cur) * K_90;
            r = p[47:27];
         end
         SCALE_95: begin
            p = 64'(cur) * K_95;
            r = p[50:30];
         end
         SCALE_102: begin
            p = 64'(cur) * K_102;
            r = p[52:32];
         end
         SCALE_105: begin
            p = 64'(cur) * K_105;
            r = p[50:30];
         end
         default: r = {1'b0, cur};
      endcase
      return r;
   endfunction

   scale_type   sel;
   logic [7:0]  loss_inc;
   logic [7:0]  stable_inc;
   logic [7:0]  probe_thr;
   logic [31:0] cool;
   logic [31:0] elapsed;
   logic        go;
   logic [20:0] scaled;
   logic [20:0] capped;
   logic [19:0] target;
   logic [2:0]  reason;
   logic        changed;
   logic [63:0] p_bal_lo;
   logic [63:0] p_ll_hi;
   logic [20:0] init_x3;
   logic [19:0] bal_lo;
   logic [19:0] bal_hi;
   logic [19:0] q_lo;
   logic [19:0] q_hi;
   logic [19:0] ll_hi;
   logic [19:0] lo_bound;
   logic [19:0] hi_bound;

   // bounds for a start word
   always_comb begin
      p_bal_lo = 64'(cfg.initial_bitrate) * K_3_10;
      p_ll_hi  = 64'(cfg.initial_bitrate) * K_6_5;
      init_x3  = 21'(cfg.initial_bitrate) * 21'd3;
      bal_lo   = p_bal_lo[44:25];
      bal_hi   = {cfg.initial_bitrate, 1'b0};
      q_lo     = {2'b00, cfg.initial_bitrate[18:1]};
      q_hi     = init_x3[20:1];
      ll_hi    = p_ll_hi[44:25];
      case (cfg.abr_mode)
         lbbc_pkg::MODE_QUALITY: begin
            lo_bound = (q_lo < FLOOR_QUAL) ? FLOOR_QUAL : q_lo;
            hi_bound = (q_hi > RATE_CAP) ? RATE_CAP : q_hi;
         end
         lbbc_pkg::MODE_LOW_LATENCY: begin
            lo_bound = FLOOR_LL;
            hi_bound = ll_hi;
         end
         default: begin
            lo_bound = (bal_lo < FLOOR_BAL) ? FLOOR_BAL : bal_lo;
            hi_bound = (bal_hi > RATE_CAP) ? RATE_CAP : bal_hi;
         end
      endcase
   end

   // tick gating
   always_comb begin
      loss_inc   = sat_inc(st.loss_run);
      stable_inc = sat_inc(st.stable_count);
      probe_thr  = (st.mode == lbbc_pkg::MODE_QUALITY) ? PROBE_QUAL : PROBE_OTHER;
      cool       = (st.mode == lbbc_pkg::MODE_LOW_LATENCY) ? COOL_LL : COOL_OTHER;
      elapsed    = item.now_ms - st.last_change_ms;
      go         = (item.opcode == lbbc_pkg::OP_TICK) && (st.ticks_seen >= DELAY_TICKS)
                   && item.stats_valid && (elapsed >= cool);
   end

   // loss classification
   always_comb begin
      sel    = SCALE_KEEP;
      reason = lbbc_pkg::REASON_NONE;
      nxt    = st;
      if (item.opcode == lbbc_pkg::OP_START) begin
         nxt          = lbbc_pkg::STATE_RESET;
         nxt.rate     = {1'b0, cfg.initial_bitrate};
         nxt.mode     = cfg.abr_mode;
         nxt.min_rate = lo_bound;
         nxt.max_rate = hi_bound;
      end else begin
         nxt.ticks_seen = sat_inc(st.ticks_seen);
         if (go) begin
            if (item.loss_centi > LOSS_EMERG) begin
               sel              = SCALE_70;
               reason           = lbbc_pkg::REASON_EMERGENCY;
               nxt.stable_count = 8'd0;
               nxt.loss_run     = loss_inc;
            end else if (item.loss_centi > LOSS_SUST) begin
               nxt.loss_run = loss_inc;
               if (loss_inc >= RUN_SUST) begin
                  sel              = SCALE_90;
                  reason           = lbbc_pkg::REASON_SUSTAINED;
                  nxt.stable_count = 8'd0;
               end
            end else if (item.loss_centi > LOSS_MILD) begin
               nxt.loss_run     = loss_inc;
               nxt.stable_count = 8'd0;
               if (loss_inc >= RUN_MILD) begin
                  sel    = SCALE_95;
                  reason = lbbc_pkg::REASON_MILD;
               end
            end else begin
               nxt.loss_run     = 8'd0;
               nxt.stable_count = stable_inc;
               if ((stable_inc >= probe_thr) && (st.rate < st.max_rate)) begin
                  // probe gentler right after backing off
                  sel = (st.last_dir == lbbc_pkg::DIR_DOWN) ? SCALE_102 : SCALE_105;
                  reason           = lbbc_pkg::REASON_PROBE;
                  nxt.stable_count = 8'd0;
               end
            end
         end
      end

      // clamp: min wins over max
      scaled  = scale_rate(st.rate, sel);
      capped  = (scaled > {1'b0, st.max_rate}) ? {1'b0, st.max_rate} : scaled;
      target  = (capped < {1'b0, st.min_rate}) ? st.min_rate : capped[19:0];
      changed = 1'b0;
      if (go && (target != st.rate)) begin
         if (reason == lbbc_pkg::REASON_NONE) begin
            reason = lbbc_pkg::REASON_CLAMP;
         end
         if (item.sink_accepts) begin
            nxt.rate           = target;
            nxt.last_dir       = (target > st.rate) ? lbbc_pkg::DIR_UP : lbbc_pkg::DIR_DOWN;
            nxt.last_change_ms = item.now_ms;
            changed            = 1'b1;
         end
      end
   end

   assign res.bitrate         = nxt.rate;
   assign res.bitrate_changed = changed;
   assign res.evaluated       = go;
   assign res.reason_code     = reason;
   assign res.direction       = nxt.last_dir;

endmodule

### src/lbbc_state.sv
// ----------------------------------------------------------------------------
// Bitrate controller state
// Controller state register, loaded when a word advances to the output.
// ----------------------------------------------------------------------------
module lbbc_state (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  lbbc_pkg::state_type nxt,
   output lbbc_pkg::state_type st
);

   lbbc_pkg::state_type state_ff;
   lbbc_pkg::state_type state_in;

   assign state_in = advance ? nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbbc_pkg::STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   assign st = state_ff;

endmodule
